// ----- hdl/dmkc_pkg.sv -----
// Shared types and constants for the direct-mapped key cache.
package dmkc_pkg;

	localparam int ENTRIES = 256;
	localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int WORD_W  = 32;

	typedef enum logic [1:0] {
		REQ_GET     = 2'd0,
		REQ_PUT     = 2'd1,
		REQ_REPLACE = 2'd2,
		REQ_CLEAR   = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EXEC = 2'b10
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;   // transaction accepted: register request, start RAM read
		logic exec;   // RAM data ready: evaluate, commit, load result
	} dmkc_cmd_t;

endpackage

// ----- hdl/dmkc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module dmkc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- hdl/dmkc_ctrl.sv -----
// Controller state machine: request handshake, sequencing and result valid.
module dmkc_ctrl import dmkc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output dmkc_cmd_t cmd
);

	state_t state_q, state_d;
	logic   rsp_valid_q;
	logic   can_exec;

	assign req_ready = (state_q == ST_IDLE);
	// result slot is free, or is being emptied this cycle
	assign can_exec  = !rsp_valid_q || rsp_ready;
	assign cmd.load  = req_valid && req_ready;
	assign cmd.exec  = (state_q == ST_EXEC) && can_exec;
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd.load) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				if (can_exec) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.exec) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- hdl/dmkc_dp.sv -----
// Datapath: key/data stores, valid bits, compare, counters and result register.
module dmkc_dp import dmkc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  dmkc_cmd_t         cmd,
	input  logic [1:0]        req_type,
	input  logic [WORD_W-1:0] key_value,
	input  logic [WORD_W-1:0] key_hash,
	input  logic [WORD_W-1:0] store_data,
	output logic              hit,
	output logic [WORD_W-1:0] read_data,
	output logic              evicted_valid,
	output logic [WORD_W-1:0] evicted_key,
	output logic [WORD_W-1:0] hit_count,
	output logic [WORD_W-1:0] lookup_count,
	output logic [WORD_W-1:0] collision_count,
	output logic [WORD_W-1:0] write_count
);

	req_t              req_s1;
	logic [WORD_W-1:0] key_s1, data_s1;
	logic [IDX_W-1:0]  slot_s1, slot_in;
	logic [WORD_W-1:0] ram_key, ram_data;
	logic [ENTRIES-1:0] valid_q;
	logic [WORD_W-1:0] hits_q, lookups_q, collisions_q, writes_q;
	logic              hit_q, ev_valid_q;
	logic [WORD_W-1:0] rdata_q, ev_key_q;

	logic slot_vld, is_hit, is_write, is_evict;

	// ENTRIES is a power of two: the modulo is a mask
	assign slot_in = IDX_W'(key_hash % WORD_W'(ENTRIES));

	assign slot_vld = valid_q[slot_s1];
	assign is_hit   = (req_s1 == REQ_GET) && slot_vld && (ram_key == key_s1);
	assign is_write = (req_s1 == REQ_PUT) || (req_s1 == REQ_REPLACE);
	assign is_evict = (req_s1 == REQ_REPLACE) && slot_vld;

	dmkc_ram #(.WIDTH(WORD_W), .DEPTH(ENTRIES)) u_key_ram (
		.clk   (clk),
		.we    (cmd.exec && is_write),
		.waddr (slot_s1),
		.wdata (key_s1),
		.re    (cmd.load),
		.raddr (slot_in),
		.rdata (ram_key)
	);

	dmkc_ram #(.WIDTH(WORD_W), .DEPTH(ENTRIES)) u_data_ram (
		.clk   (clk),
		.we    (cmd.exec && is_write),
		.waddr (slot_s1),
		.wdata (data_s1),
		.re    (cmd.load),
		.raddr (slot_in),
		.rdata (ram_data)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_s1  <= req_t'(req_type);
			key_s1  <= key_value;
			data_s1 <= store_data;
			slot_s1 <= slot_in;
		end
		if (cmd.exec) begin
			hit_q      <= is_hit;
			rdata_q    <= is_hit ? ram_data : '0;
			ev_valid_q <= is_evict;
			ev_key_q   <= is_evict ? ram_key : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= '0;
			hits_q       <= '0;
			lookups_q    <= '0;
			collisions_q <= '0;
			writes_q     <= '0;
		end else if (cmd.exec) begin
			case (req_s1)
				REQ_GET: begin
					lookups_q <= lookups_q + 1'b1;
					if (is_hit) hits_q <= hits_q + 1'b1;
				end
				REQ_PUT: begin
					writes_q         <= writes_q + 1'b1;
					valid_q[slot_s1] <= 1'b1;
				end
				REQ_REPLACE: begin
					writes_q         <= writes_q + 1'b1;
					valid_q[slot_s1] <= 1'b1;
					if (is_evict) collisions_q <= collisions_q + 1'b1;
				end
				REQ_CLEAR: begin
					valid_q <= '0;
				end
				default: begin
					valid_q <= valid_q;
				end
			endcase
		end
	end

	// counters only move on exec, so they hold with the pending result
	assign hit             = hit_q;
	assign read_data       = rdata_q;
	assign evicted_valid   = ev_valid_q;
	assign evicted_key     = ev_key_q;
	assign hit_count       = hits_q;
	assign lookup_count    = lookups_q;
	assign collision_count = collisions_q;
	assign write_count     = writes_q;

endmodule

// ----- hdl/direct_mapped_key_cache_top.sv -----
// Top level of the direct-mapped key cache.
//
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------------
//  req     | req_valid/req_ready  | req_type, key_value, key_hash, store_data
//  rsp     | rsp_valid/rsp_ready  | hit, read_data, evicted_valid, evicted_key,
//          |                      | hit_count, lookup_count, collision_count,
//          |                      | write_count
//
// Each transaction runs as accept and RAM read, then evaluate and write back,
// an order set by the registered read of the key/data RAMs.
// Clear drops all valid bits at once; the stores keep their contents.
// Reset clears valid bits and counters at once; no clearing pass is needed.
// A pending result stalls evaluation of the next request until taken.
module direct_mapped_key_cache_top import dmkc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  logic [1:0]        req_type,
	input  logic [WORD_W-1:0] key_value,
	input  logic [WORD_W-1:0] key_hash,
	input  logic [WORD_W-1:0] store_data,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output logic              hit,
	output logic [WORD_W-1:0] read_data,
	output logic              evicted_valid,
	output logic [WORD_W-1:0] evicted_key,
	output logic [WORD_W-1:0] hit_count,
	output logic [WORD_W-1:0] lookup_count,
	output logic [WORD_W-1:0] collision_count,
	output logic [WORD_W-1:0] write_count
);

	dmkc_cmd_t cmd;

	dmkc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.cmd       (cmd)
	);

	dmkc_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.req_type        (req_type),
		.key_value       (key_value),
		.key_hash        (key_hash),
		.store_data      (store_data),
		.hit             (hit),
		.read_data       (read_data),
		.evicted_valid   (evicted_valid),
		.evicted_key     (evicted_key),
		.hit_count       (hit_count),
		.lookup_count    (lookup_count),
		.collision_count (collision_count),
		.write_count     (write_count)
	);

endmodule

// ----- hdl/dmkc_checker.sv -----
// Port-level checker for the direct-mapped key cache, bound to the top level.
module dmkc_checker import dmkc_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_ready,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input logic              hit,
	input logic [WORD_W-1:0] read_data,
	input logic              evicted_valid,
	input logic [WORD_W-1:0] evicted_key,
	input logic [WORD_W-1:0] hit_count
);

	// a stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(read_data)
			&& $stable(hit) && $stable(evicted_key) && $stable(hit_count))
		else $error("result changed while stalled");

	// one transaction in flight at a time
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while previous one in flight");

	a_miss_data_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !hit |-> read_data == '0)
		else $error("read_data non-zero without hit");

	a_no_evict_key_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !evicted_valid |-> evicted_key == '0)
		else $error("evicted_key non-zero without eviction");

	// a get never evicts
	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && hit |-> !evicted_valid)
		else $error("hit and eviction in one result");

endmodule

bind direct_mapped_key_cache_top dmkc_checker u_dmkc_checker (.*);
